/* sv/ghpp_pkg.sv */
// Shared types and codes for the grammar Huffman position probe.
// Item structs, configuration struct, table selects, status and register codes.
// No dependencies.
package ghpp_pkg;

    typedef struct packed {
        logic        func;
        logic [2:0]  table_sel;
        logic [13:0] address;
        logic [63:0] write_data;
        logic [25:0] position;
    } t_in_item;

    typedef struct packed {
        logic [11:0] terminal_value;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic [5:0]  min_code_len;
        logic [5:0]  num_lengths;
        logic [4:0]  log2_block_bytes;
        logic [4:0]  log2_span;
        logic [10:0] num_blocks;
        logic [11:0] terminal_count;
    } t_cfg;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_PROBE = 1'b1;

    localparam logic [2:0] TBL_RULE   = 3'd0;
    localparam logic [2:0] TBL_EXPLEN = 3'd1;
    localparam logic [2:0] TBL_SYMORD = 3'd2;
    localparam logic [2:0] TBL_GSTART = 3'd3;
    localparam logic [2:0] TBL_BASE   = 3'd4;
    localparam logic [2:0] TBL_BLKLEN = 3'd5;
    localparam logic [2:0] TBL_SPARSE = 3'd6;
    localparam logic [2:0] TBL_ENC    = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [2:0] REG_MIN_LEN    = 3'd0;
    localparam logic [2:0] REG_NUM_LENS   = 3'd1;
    localparam logic [2:0] REG_LOG2_BLOCK = 3'd2;
    localparam logic [2:0] REG_LOG2_SPAN  = 3'd3;
    localparam logic [2:0] REG_NUM_BLOCKS = 3'd4;
    localparam logic [2:0] REG_TERM_COUNT = 3'd5;

    localparam logic [5:0]  RST_MIN_LEN    = 6'd1;
    localparam logic [5:0]  RST_NUM_LENS   = 6'd1;
    localparam logic [4:0]  RST_LOG2_BLOCK = 5'd6;
    localparam logic [4:0]  RST_LOG2_SPAN  = 5'd6;
    localparam logic [10:0] RST_NUM_BLOCKS = 11'd0;
    localparam logic [11:0] RST_TERM_COUNT = 12'd4;

    localparam int CFG_ADDR_W = 5;

endpackage

/* sv/grammar_huffman_position_probe_core.sv */
// Top level of the grammar Huffman position probe: table stores, probe sequencer.
// Depends on ghpp_pkg, ghpp_ram and ghpp_cfg.
//
//  channel | direction | handshake            | payload
//  in      | input     | i_in_valid/o_in_ready | i_in  (t_in_item)
//  out     | output    | o_out_valid/i_out_ready | o_out (t_out_item)
//  cfg     | input     | psel/penable/pwrite  | paddr, pwdata, prdata
//
// A table write leaves the input ready. A probe reads the sparse entry, steps
// through blocks, decodes Huffman symbols and descends rule levels; every step
// is one read of a single-port table store, the encoded store taking three reads
// per window.
// Reset is synchronous and clears the sequencer and the output valid flag; table
// contents are not cleared. A finished result waits in the output register while
// new items are accepted; the sequencer holds its result until that register frees.
module grammar_huffman_position_probe_core #(
    parameter int MAX_SYMBOLS    = 4096,
    parameter int MAX_LENGTHS    = 32,
    parameter int MAX_BLOCKS     = 1024,
    parameter int SPARSE_ENTRIES = 1024,
    parameter int ENC_WORDS      = 16384
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ghpp_pkg::t_in_item              i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ghpp_pkg::t_out_item             o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ghpp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int SYM_AW  = $clog2(MAX_SYMBOLS);
    localparam int LEN_AW  = (MAX_LENGTHS > 1) ? $clog2(MAX_LENGTHS) : 1;
    localparam int BLK_AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SPR_AW  = (SPARSE_ENTRIES > 1) ? $clog2(SPARSE_ENTRIES) : 1;
    localparam int ENC_AW  = $clog2(ENC_WORDS);
    localparam int BLK_W   = ($clog2(MAX_BLOCKS + 1) > 11) ? $clog2(MAX_BLOCKS + 1) : 11;
    localparam int STEP_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int OFF_W   = 35;
    localparam int BIT_W   = 24;

    typedef enum logic [4:0] {
        S_IDLE, S_SPARSE_RD, S_SPARSE, S_BACK, S_BACK_RD, S_BACK_ADD, S_FWD, S_FWD_CMP,
        S_WIN0, S_WIN1, S_WIN2, S_WIN3, S_GRP0, S_GRP1, S_GRP_RD, S_GRP_CMP,
        S_IDX0, S_IDX1, S_SYM_RD, S_SYM, S_EXP_RD, S_EXP, S_DESC_CHK,
        S_RULE_RD, S_RULE, S_LEFT_RD, S_LEFT, S_DEXP_RD, S_DEXP, S_DONE
    } t_state;

    ghpp_pkg::t_cfg      cfg;
    t_state              r_state;
    logic                r_zero;
    logic                n_zero;
    logic [25:0]         r_pos;
    logic [SPR_AW-1:0]   r_k;
    logic [BLK_W-1:0]    r_block;
    logic signed [OFF_W-1:0] r_off;
    logic [BIT_W-1:0]    r_bitpos;
    logic [31:0]         r_w0;
    logic [31:0]         r_w1;
    logic [63:0]         r_win;
    logic [63:0]         r_base;
    logic [63:0]         r_diff;
    logic [4:0]          r_g;
    logic [32:0]         r_idx;
    logic [11:0]         r_sym;
    logic [15:0]         r_explen;
    logic [23:0]         r_rule;
    logic [STEP_W-1:0]   r_steps;
    logic [1:0]          r_status;
    logic                r_out_valid;
    ghpp_pkg::t_out_item r_out;

    // clamped configuration
    logic [BLK_W-1:0] nb_sat;
    logic [5:0]       minl;
    logic [5:0]       nl;
    logic [4:0]       lbb;
    logic [4:0]       wshift;
    logic [31:0]      words;
    logic [31:0]      first;
    logic [31:0]      span;
    logic [25:0]      pos_k;

    always_comb begin
        nb_sat = (32'(cfg.num_blocks) > 32'(MAX_BLOCKS)) ? BLK_W'(MAX_BLOCKS)
                                                         : BLK_W'(cfg.num_blocks);
        if (cfg.min_code_len == 6'd0) minl = 6'd1;
        else if (cfg.min_code_len > 6'd32) minl = 6'd32;
        else minl = cfg.min_code_len;
        if (cfg.num_lengths == 6'd0) nl = 6'd1;
        else if (32'(cfg.num_lengths) > 32'(MAX_LENGTHS)) nl = 6'(MAX_LENGTHS);
        else nl = cfg.num_lengths;
        if (cfg.log2_block_bytes < 5'd3) lbb = 5'd3;
        else if (cfg.log2_block_bytes > 5'd16) lbb = 5'd16;
        else lbb = cfg.log2_block_bytes;
    end

    assign wshift = lbb - 5'd2;
    assign words  = 32'd1 << wshift;
    assign first  = 32'(r_block) << wshift;
    assign span   = 32'd1 << cfg.log2_span;
    assign pos_k  = i_in.position >> cfg.log2_span;

    // handshake
    logic in_acc;
    logic wr_acc;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign wr_acc     = in_acc && (i_in.func == ghpp_pkg::FUNC_WRITE);

    // table stores
    logic [23:0] rule_rd;
    logic [15:0] exp_rd;
    logic [11:0] ord_rd;
    logic [12:0] gs_rd;
    logic [63:0] base_rd;
    logic [15:0] blk_rd;
    logic [41:0] spr_rd;
    logic [31:0] enc_rd;

    logic [SYM_AW-1:0] rule_addr, exp_addr, ord_addr;
    logic [LEN_AW-1:0] gs_addr, base_addr;
    logic [BLK_AW-1:0] blk_addr;
    logic [SPR_AW-1:0] spr_addr;
    logic [ENC_AW-1:0] enc_addr;
    logic [11:0]       rule_idx;
    logic [31:0]       enc_j;
    logic [31:0]       enc_abs;
    logic              enc_zero;
    logic              idle;

    assign idle     = (r_state == S_IDLE);
    assign rule_idx = r_sym - cfg.terminal_count;

    always_comb begin
        case (r_state)
            S_WIN1:  enc_j = 32'(r_bitpos[BIT_W-1:5]) + 32'd1;
            S_WIN2:  enc_j = 32'(r_bitpos[BIT_W-1:5]) + 32'd2;
            default: enc_j = 32'(r_bitpos[BIT_W-1:5]);
        endcase
    end

    assign enc_abs  = first + enc_j;
    assign enc_zero = (enc_j >= words) || (enc_abs >= 32'(ENC_WORDS));

    assign rule_addr = idle ? SYM_AW'(i_in.address) : SYM_AW'(rule_idx);
    assign exp_addr  = idle ? SYM_AW'(i_in.address)
                     : (r_state == S_LEFT_RD) ? SYM_AW'(r_rule[11:0]) : SYM_AW'(r_sym);
    assign ord_addr  = idle ? SYM_AW'(i_in.address) : SYM_AW'(r_idx);
    assign gs_addr   = idle ? LEN_AW'(i_in.address) : LEN_AW'(r_g);
    assign base_addr = idle ? LEN_AW'(i_in.address)
                     : (r_state == S_GRP_RD) ? LEN_AW'(6'(r_g) + 6'd1) : LEN_AW'(0);
    assign blk_addr  = idle ? BLK_AW'(i_in.address) : BLK_AW'(r_block);
    assign spr_addr  = idle ? SPR_AW'(i_in.address) : r_k;
    assign enc_addr  = idle ? ENC_AW'(i_in.address) : ENC_AW'(enc_abs);

    logic we_rule, we_exp, we_ord, we_gs, we_base, we_blk, we_spr, we_enc;
    assign we_rule = wr_acc && (i_in.table_sel == ghpp_pkg::TBL_RULE)
                     && (32'(i_in.address) < 32'(MAX_SYMBOLS));
    assign we_exp  = wr_acc && (i_in.table_sel == ghpp_pkg::TBL_EXPLEN)
                     && (32'(i_in.address) < 32'(MAX_SYMBOLS));
    assign we_ord  = wr_acc && (i_in.table_sel == ghpp_pkg::TBL_SYMORD)
                     && (32'(i_in.address) < 32'(MAX_SYMBOLS));
    assign we_gs   = wr_acc && (i_in.table_sel == ghpp_pkg::TBL_GSTART)
                     && (32'(i_in.address) < 32'(MAX_LENGTHS));
    assign we_base = wr_acc && (i_in.table_sel == ghpp_pkg::TBL_BASE)
                     && (32'(i_in.address) < 32'(MAX_LENGTHS));
    assign we_blk  = wr_acc && (i_in.table_sel == ghpp_pkg::TBL_BLKLEN)
                     && (32'(i_in.address) < 32'(MAX_BLOCKS));
    assign we_spr  = wr_acc && (i_in.table_sel == ghpp_pkg::TBL_SPARSE)
                     && (32'(i_in.address) < 32'(SPARSE_ENTRIES));
    assign we_enc  = wr_acc && (i_in.table_sel == ghpp_pkg::TBL_ENC)
                     && (32'(i_in.address) < 32'(ENC_WORDS));

    ghpp_ram #(.WIDTH(24), .DEPTH(MAX_SYMBOLS), .AW(SYM_AW)) u_rule_ram (
        .i_clk(i_clk), .i_we(we_rule), .i_addr(rule_addr),
        .i_wdata(i_in.write_data[23:0]), .o_rdata(rule_rd));
    ghpp_ram #(.WIDTH(16), .DEPTH(MAX_SYMBOLS), .AW(SYM_AW)) u_exp_ram (
        .i_clk(i_clk), .i_we(we_exp), .i_addr(exp_addr),
        .i_wdata(i_in.write_data[15:0]), .o_rdata(exp_rd));
    ghpp_ram #(.WIDTH(12), .DEPTH(MAX_SYMBOLS), .AW(SYM_AW)) u_ord_ram (
        .i_clk(i_clk), .i_we(we_ord), .i_addr(ord_addr),
        .i_wdata(i_in.write_data[11:0]), .o_rdata(ord_rd));
    ghpp_ram #(.WIDTH(13), .DEPTH(MAX_LENGTHS), .AW(LEN_AW)) u_gs_ram (
        .i_clk(i_clk), .i_we(we_gs), .i_addr(gs_addr),
        .i_wdata(i_in.write_data[12:0]), .o_rdata(gs_rd));
    ghpp_ram #(.WIDTH(64), .DEPTH(MAX_LENGTHS), .AW(LEN_AW)) u_base_ram (
        .i_clk(i_clk), .i_we(we_base), .i_addr(base_addr),
        .i_wdata(i_in.write_data), .o_rdata(base_rd));
    ghpp_ram #(.WIDTH(16), .DEPTH(MAX_BLOCKS), .AW(BLK_AW)) u_blk_ram (
        .i_clk(i_clk), .i_we(we_blk), .i_addr(blk_addr),
        .i_wdata(i_in.write_data[15:0]), .o_rdata(blk_rd));
    ghpp_ram #(.WIDTH(42), .DEPTH(SPARSE_ENTRIES), .AW(SPR_AW)) u_spr_ram (
        .i_clk(i_clk), .i_we(we_spr), .i_addr(spr_addr),
        .i_wdata(i_in.write_data[41:0]), .o_rdata(spr_rd));
    ghpp_ram #(.WIDTH(32), .DEPTH(ENC_WORDS), .AW(ENC_AW)) u_enc_ram (
        .i_clk(i_clk), .i_we(we_enc), .i_addr(enc_addr),
        .i_wdata(i_in.write_data[31:0]), .o_rdata(enc_rd));

    ghpp_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cfg(cfg));

    // reads past a table's end return zero: flag them when issued
    always_comb begin
        case (r_state)
            S_WIN0, S_WIN1, S_WIN2: n_zero = enc_zero;
            S_SYM_RD:               n_zero = (r_idx >= 33'(MAX_SYMBOLS));
            S_EXP_RD, S_DEXP_RD:    n_zero = (32'(r_sym) >= 32'(MAX_SYMBOLS));
            S_LEFT_RD:              n_zero = (32'(r_rule[11:0]) >= 32'(MAX_SYMBOLS));
            S_RULE_RD:              n_zero = (32'(rule_idx) >= 32'(MAX_SYMBOLS));
            default:                n_zero = 1'b0;
        endcase
    end

    logic [23:0] rule_q;
    logic [15:0] exp_q;
    logic [11:0] ord_q;
    logic [31:0] enc_q;
    assign rule_q = r_zero ? 24'd0 : rule_rd;
    assign exp_q  = r_zero ? 16'd0 : exp_rd;
    assign ord_q  = r_zero ? 12'd0 : ord_rd;
    assign enc_q  = r_zero ? 32'd0 : enc_rd;

    // datapath helpers
    logic signed [OFF_W-1:0] off_init;
    logic signed [OFF_W-1:0] blk_len1;
    logic signed [OFF_W-1:0] exp_len1;
    logic signed [OFF_W-1:0] back_sum;
    logic [63:0]             win_new;
    logic [63:0]             win_lo;
    logic [4:0]              bsh;
    logic [6:0]              idx_sh;
    logic [63:0]             diff_sh;

    assign off_init = $signed(OFF_W'(spr_rd[31:0])
                      + (OFF_W'(r_pos) & OFF_W'(span - 32'd1))
                      - OFF_W'(span >> 1));
    assign blk_len1 = $signed(OFF_W'(blk_rd) + OFF_W'(1));
    assign exp_len1 = $signed(OFF_W'(exp_q) + OFF_W'(1));
    assign back_sum = r_off + blk_len1;

    assign bsh     = r_bitpos[4:0];
    assign win_lo  = (bsh == 5'd0) ? 64'd0 : ({32'd0, enc_q} >> (6'd32 - 6'(bsh)));
    assign win_new = ({r_w0, r_w1} << bsh) | win_lo;

    assign idx_sh  = 7'd64 - 7'(r_g) - 7'(minl);
    assign diff_sh = r_diff >> idx_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_zero      <= 1'b0;
        end else begin
            r_zero <= n_zero;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in.func == ghpp_pkg::FUNC_PROBE) begin
                        r_pos <= i_in.position;
                        r_k   <= SPR_AW'(pos_k);
                        if (nb_sat == '0) begin
                            r_status <= ghpp_pkg::ST_EMPTY;
                            r_state  <= S_DONE;
                        end else if (32'(pos_k) >= 32'(SPARSE_ENTRIES)) begin
                            r_status <= ghpp_pkg::ST_RANGE;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SPARSE_RD;
                        end
                    end
                end
                S_SPARSE_RD: r_state <= S_SPARSE;
                S_SPARSE: begin
                    r_block <= BLK_W'(spr_rd[41:32]);
                    r_off   <= off_init;
                    r_state <= (off_init < 0) ? S_BACK : S_FWD;
                end
                S_BACK: begin
                    if (r_block == '0 || (r_block - BLK_W'(1)) >= nb_sat) begin
                        r_status <= ghpp_pkg::ST_RANGE;
                        r_state  <= S_DONE;
                    end else begin
                        r_block <= r_block - BLK_W'(1);
                        r_state <= S_BACK_RD;
                    end
                end
                S_BACK_RD: r_state <= S_BACK_ADD;
                S_BACK_ADD: begin
                    r_off   <= back_sum;
                    r_state <= (back_sum < 0) ? S_BACK : S_FWD;
                end
                S_FWD: begin
                    if (r_block >= nb_sat) begin
                        r_status <= ghpp_pkg::ST_RANGE;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_FWD_CMP;
                    end
                end
                S_FWD_CMP: begin
                    if (r_off <= $signed(OFF_W'(blk_rd))) begin
                        r_bitpos <= '0;
                        r_state  <= S_WIN0;
                    end else begin
                        r_off   <= r_off - blk_len1;
                        r_block <= r_block + BLK_W'(1);
                        r_state <= S_FWD;
                    end
                end
                S_WIN0: r_state <= S_WIN1;
                S_WIN1: begin
                    r_w0    <= enc_q;
                    r_state <= S_WIN2;
                end
                S_WIN2: begin
                    r_w1    <= enc_q;
                    r_state <= S_WIN3;
                end
                S_WIN3: begin
                    r_win   <= win_new;
                    r_state <= S_GRP0;
                end
                S_GRP0: r_state <= S_GRP1;
                S_GRP1: begin
                    r_base  <= base_rd;
                    r_g     <= '0;
                    r_state <= (nl > 6'd1) ? S_GRP_RD : S_IDX0;
                end
                S_GRP_RD: r_state <= S_GRP_CMP;
                S_GRP_CMP: begin
                    if (r_win >= base_rd) begin
                        r_g     <= r_g + 5'd1;
                        r_base  <= base_rd;
                        r_state <= ((6'(r_g) + 6'd2) < nl) ? S_GRP_RD : S_IDX0;
                    end else begin
                        r_state <= S_IDX0;
                    end
                end
                S_IDX0: begin
                    r_diff  <= r_win - r_base;
                    r_state <= S_IDX1;
                end
                S_IDX1: begin
                    r_idx   <= 33'(diff_sh[31:0]) + 33'(gs_rd);
                    r_state <= S_SYM_RD;
                end
                S_SYM_RD: r_state <= S_SYM;
                S_SYM: begin
                    r_sym   <= ord_q;
                    r_state <= S_EXP_RD;
                end
                S_EXP_RD: r_state <= S_EXP;
                S_EXP: begin
                    r_explen <= exp_q;
                    if (r_off < exp_len1) begin
                        r_steps <= '0;
                        r_state <= S_DESC_CHK;
                    end else begin
                        r_off    <= r_off - exp_len1;
                        r_bitpos <= r_bitpos + BIT_W'(r_g) + BIT_W'(minl);
                        r_state  <= S_WIN0;
                    end
                end
                S_DESC_CHK: begin
                    if (32'(r_steps) >= 32'(MAX_SYMBOLS) || r_sym < cfg.terminal_count
                        || r_explen == 16'd0) begin
                        r_status <= ghpp_pkg::ST_OK;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_RULE_RD;
                    end
                end
                S_RULE_RD: r_state <= S_RULE;
                S_RULE: begin
                    r_rule  <= rule_q;
                    r_state <= S_LEFT_RD;
                end
                S_LEFT_RD: r_state <= S_LEFT;
                S_LEFT: begin
                    // go left when the offset falls inside the left expansion
                    if (r_off < exp_len1) begin
                        r_sym <= r_rule[11:0];
                    end else begin
                        r_off <= r_off - exp_len1;
                        r_sym <= r_rule[23:12];
                    end
                    r_state <= S_DEXP_RD;
                end
                S_DEXP_RD: r_state <= S_DEXP;
                S_DEXP: begin
                    r_explen <= exp_q;
                    r_steps  <= r_steps + STEP_W'(1);
                    r_state  <= S_DESC_CHK;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid          <= 1'b1;
                        r_out.status         <= r_status;
                        r_out.terminal_value <= (r_status == ghpp_pkg::ST_OK) ? r_sym : 12'd0;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    a_err_zero_terminal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ghpp_pkg::ST_OK) |-> (o_out.terminal_value == 12'd0))
        else $error("error result carries a nonzero terminal");

    a_probe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.func == ghpp_pkg::FUNC_PROBE) |=> !o_in_ready)
        else $error("probe item did not start the sequencer");

    a_write_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.func == ghpp_pkg::FUNC_WRITE) |=> o_in_ready)
        else $error("table write held the input side");

    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DESC_CHK) |-> (32'(r_steps) <= 32'(MAX_SYMBOLS)))
        else $error("rule descent ran past its step bound");
`endif

endmodule

/* sv/ghpp_ram.sv */
// Generic single-port RAM with registered read data.
// One write or one read address per cycle. No dependencies.
module ghpp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/ghpp_cfg.sv */
// APB-style configuration registers of the position probe.
// Depends on ghpp_pkg for the register codes, reset values and t_cfg.
module ghpp_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ghpp_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output ghpp_pkg::t_cfg                   o_cfg
);

    ghpp_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_code_len     <= ghpp_pkg::RST_MIN_LEN;
            r_cfg.num_lengths      <= ghpp_pkg::RST_NUM_LENS;
            r_cfg.log2_block_bytes <= ghpp_pkg::RST_LOG2_BLOCK;
            r_cfg.log2_span        <= ghpp_pkg::RST_LOG2_SPAN;
            r_cfg.num_blocks       <= ghpp_pkg::RST_NUM_BLOCKS;
            r_cfg.terminal_count   <= ghpp_pkg::RST_TERM_COUNT;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                ghpp_pkg::REG_MIN_LEN:    r_cfg.min_code_len     <= pwdata[5:0];
                ghpp_pkg::REG_NUM_LENS:   r_cfg.num_lengths      <= pwdata[5:0];
                ghpp_pkg::REG_LOG2_BLOCK: r_cfg.log2_block_bytes <= pwdata[4:0];
                ghpp_pkg::REG_LOG2_SPAN:  r_cfg.log2_span        <= pwdata[4:0];
                ghpp_pkg::REG_NUM_BLOCKS: r_cfg.num_blocks       <= pwdata[10:0];
                ghpp_pkg::REG_TERM_COUNT: r_cfg.terminal_count   <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ghpp_pkg::REG_MIN_LEN:    prdata = 32'(r_cfg.min_code_len);
            ghpp_pkg::REG_NUM_LENS:   prdata = 32'(r_cfg.num_lengths);
            ghpp_pkg::REG_LOG2_BLOCK: prdata = 32'(r_cfg.log2_block_bytes);
            ghpp_pkg::REG_LOG2_SPAN:  prdata = 32'(r_cfg.log2_span);
            ghpp_pkg::REG_NUM_BLOCKS: prdata = 32'(r_cfg.num_blocks);
            ghpp_pkg::REG_TERM_COUNT: prdata = 32'(r_cfg.terminal_count);
            default:                  prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
